[rtl/tes_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Tab expander package
// Shared constants, register indexes and the command type passed from the
// classifying front end to the expanding back end.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int TES_STOP_COUNT = 7;
    localparam int TES_REG_W      = 7;
    localparam int TES_CFG_IDX_W  = 3;
    localparam int TES_COL_W      = 6;
    localparam int TES_BYTE_W     = 8;
    localparam int TES_Q_DEPTH    = 4;
    localparam int TES_Q_PTR_W    = 2;

    localparam logic [TES_CFG_IDX_W-1:0] TES_IDX_DEFAULT_WIDTH = 3'd7;

    localparam logic [TES_BYTE_W-1:0] TES_TAB_BYTE   = 8'd9;
    localparam logic [TES_BYTE_W-1:0] TES_SPACE_BYTE = 8'd32;
    localparam logic [TES_REG_W-1:0]  TES_WIDTH_MAX  = 7'd64;
    localparam logic [TES_REG_W-1:0]  TES_WIDTH_MIN  = 7'd1;
    localparam logic [TES_REG_W-1:0]  TES_DEFAULT_WIDTH_RESET = 7'd10;

    typedef struct packed {
        logic                  is_tab;
        logic [TES_BYTE_W-1:0] data;
    } t_tes_cmd;

endpackage
`default_nettype wire

[rtl/tes_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Tab expander front end
// Holds the stop list, tracks column and list pointer, and turns accepted
// bytes into copy commands and tabs into run-of-spaces commands, if any.
// ----------------------------------------------------------------------------
module tes_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [tes_pkg::TES_CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tes_pkg::TES_REG_W-1:0]       i_cfg_data,
    input  wire logic                                i_push,
    input  wire logic [tes_pkg::TES_BYTE_W-1:0]      i_in_byte,
    input  wire logic                                i_q_full,
    output logic                                     o_cmd_push,
    output tes_pkg::t_tes_cmd                        o_cmd
);
    import tes_pkg::*;

    logic [TES_REG_W-1:0]     r_stop_width [TES_STOP_COUNT];
    logic [TES_REG_W-1:0]     r_default_width;
    logic [TES_COL_W-1:0]     r_column;
    logic [TES_COL_W-1:0]     n_column;
    logic [TES_CFG_IDX_W-1:0] r_stop_index;
    logic [TES_CFG_IDX_W-1:0] n_stop_index;

    logic                 accept;
    logic                 is_tab;
    logic                 in_list;
    logic [TES_REG_W-1:0] list_raw;
    logic                 from_list;
    logic [TES_REG_W-1:0] raw_width;
    logic [TES_REG_W-1:0] width;
    logic [TES_REG_W-1:0] col_ext;
    logic [TES_REG_W-1:0] col_inc;
    logic [TES_REG_W-1:0] space_count;

    always_comb begin
        accept    = i_push && !i_q_full;
        is_tab    = (i_in_byte == TES_TAB_BYTE);
        in_list   = (r_stop_index < TES_CFG_IDX_W'(TES_STOP_COUNT));
        list_raw  = in_list ? r_stop_width[r_stop_index] : '0;
        from_list = in_list && (list_raw != '0);
        raw_width = from_list ? list_raw : r_default_width;
        if (raw_width > TES_WIDTH_MAX) begin
            width = TES_WIDTH_MAX;
        end else if (raw_width == '0) begin
            width = TES_WIDTH_MIN;
        end else begin
            width = raw_width;
        end
        col_ext     = {1'b0, r_column};
        col_inc     = col_ext + TES_REG_W'(1);
        space_count = (col_ext < width) ? (width - col_ext) : '0;

        n_column     = r_column;
        n_stop_index = r_stop_index;
        o_cmd_push   = 1'b0;
        o_cmd.is_tab = is_tab;
        o_cmd.data   = is_tab ? {1'b0, space_count} : i_in_byte;
        if (accept) begin
            if (is_tab) begin
                n_column   = '0;
                o_cmd_push = (space_count != '0);
                if (from_list) begin
                    n_stop_index = r_stop_index + TES_CFG_IDX_W'(1);
                end
            end else begin
                o_cmd_push = 1'b1;
                if ((col_inc == width) || (col_inc >= TES_WIDTH_MAX)) begin
                    n_column = '0;
                end else begin
                    n_column = col_inc[TES_COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TES_STOP_COUNT; i++) begin
                r_stop_width[i] <= '0;
            end
            r_default_width <= TES_DEFAULT_WIDTH_RESET;
            r_column        <= '0;
            r_stop_index    <= '0;
        end else begin
            r_column     <= n_column;
            r_stop_index <= n_stop_index;
            if (i_cfg_we) begin
                if (i_cfg_index == TES_IDX_DEFAULT_WIDTH) begin
                    r_default_width <= i_cfg_data;
                end else if (i_cfg_index < TES_CFG_IDX_W'(TES_STOP_COUNT)) begin
                    r_stop_width[i_cfg_index] <= i_cfg_data;
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/tes_cmd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Tab expander command queue
// A short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tes_cmd_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  tes_pkg::t_tes_cmd      i_cmd,
    output logic                   o_full,
    input  wire logic              i_pop,
    output tes_pkg::t_tes_cmd      o_cmd,
    output logic                   o_empty
);
    import tes_pkg::*;

    t_tes_cmd               r_entry [TES_Q_DEPTH];
    logic [TES_Q_PTR_W-1:0] r_wr_ptr;
    logic [TES_Q_PTR_W-1:0] r_rd_ptr;
    logic [TES_Q_PTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    always_comb begin
        o_full  = (r_count == (TES_Q_PTR_W+1)'(TES_Q_DEPTH));
        o_empty = (r_count == '0);
        o_cmd   = r_entry[r_rd_ptr];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + TES_Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + TES_Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (TES_Q_PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (TES_Q_PTR_W+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/tes_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Tab expander back end
// Executes queued commands, emitting one output byte per cycle into a
// result register while results are taken.
// ----------------------------------------------------------------------------
module tes_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_empty,
    input  tes_pkg::t_tes_cmd                    i_cmd,
    output logic                                 o_q_pop,
    input  wire logic                            i_pop,
    output logic                                 o_empty,
    output logic [tes_pkg::TES_BYTE_W-1:0]       o_out_byte,
    output logic                                 o_last
);
    import tes_pkg::*;

    logic                  r_busy;
    logic [TES_REG_W-1:0]  r_remain;
    logic                  r_out_valid;
    logic [TES_BYTE_W-1:0] r_out_byte;
    logic                  r_last;

    logic                  load;
    logic [TES_REG_W-1:0]  cmd_count;

    always_comb begin
        load      = !r_out_valid || i_pop;
        o_q_pop   = load && !r_busy && !i_q_empty;
        cmd_count = i_cmd.data[TES_REG_W-1:0];
        o_empty    = !r_out_valid;
        o_out_byte = r_out_byte;
        o_last     = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_busy) begin
                r_out_byte <= TES_SPACE_BYTE;
                r_last     <= (r_remain == TES_REG_W'(1));
            end else if (!i_q_empty) begin
                r_out_byte <= i_cmd.is_tab ? TES_SPACE_BYTE : i_cmd.data;
                r_last     <= !i_cmd.is_tab || (cmd_count == TES_REG_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            if (r_busy) begin
                r_out_valid <= 1'b1;
                r_remain    <= r_remain - TES_REG_W'(1);
                r_busy      <= (r_remain != TES_REG_W'(1));
            end else if (!i_q_empty) begin
                r_out_valid <= 1'b1;
                if (i_cmd.is_tab && (cmd_count != TES_REG_W'(1))) begin
                    r_busy   <= 1'b1;
                    r_remain <= cmd_count - TES_REG_W'(1);
                end
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/tab_expander_stop_list_top.sv]
`default_nettype none
// A byte enters the command queue at its accepting edge; its first result is then moved
// to the output register when the back end is free; a four-entry queue lets input run ahead.
// Throughput: one byte per cycle for copied bytes while the queue is not full.
// Output: one result per cycle, tab spaces included, while results are taken.
// Reset is synchronous, active low: column, list pointer and queues clear,
// stop widths clear to zero and the default width returns to ten.
// ----------------------------------------------------------------------------
// Tab expander with tab-stop list, top level
// Connects the classifying front end, the command queue and the back end.
// ----------------------------------------------------------------------------
module tab_expander_stop_list_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tes_pkg::TES_CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tes_pkg::TES_REG_W-1:0]     i_cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [tes_pkg::TES_BYTE_W-1:0]    i_in_byte,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [tes_pkg::TES_BYTE_W-1:0]         o_out_byte,
    output logic                                   o_last
);
    import tes_pkg::*;

    logic     cmd_push;
    t_tes_cmd cmd_in;
    t_tes_cmd cmd_out;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;

    assign full = q_full;

    tes_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_in_byte   (i_in_byte),
        .i_q_full    (q_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    tes_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (cmd_out),
        .o_empty (q_empty)
    );

    tes_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_cmd      (cmd_out),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule
`default_nettype wire

[rtl/tes_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Tab expander port checker
// Concurrent checks on the result side of the top level, bound to it.
// ----------------------------------------------------------------------------
module tes_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_empty,
    input wire logic                           i_pop,
    input wire logic [tes_pkg::TES_BYTE_W-1:0] i_out_byte,
    input wire logic                           i_last
);
    import tes_pkg::*;

    // A waiting result stays while it is not taken.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> !i_empty)
        else $error("result withdrawn before it was taken");

    // A waiting result does not change while it is not taken.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> ($stable(i_out_byte) && $stable(i_last)))
        else $error("result changed before it was taken");

    // Only spaces of a tab run can be followed by more results of the same request.
    a_copy_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && (i_out_byte != TES_SPACE_BYTE)) |-> i_last)
        else $error("copied byte not marked last");

    // Taking a space that is not last leaves the next space ready at once.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_pop && !i_last) |=> !i_empty)
        else $error("tab run interrupted");

endmodule

bind tab_expander_stop_list_top tes_checker u_tes_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_empty    (empty),
    .i_pop      (pop),
    .i_out_byte (o_out_byte),
    .i_last     (o_last)
);
`default_nettype wire
